// File: rtl/snm_pkg.sv
package snm_pkg;

    typedef logic [7:0] pixel_t;
    typedef pixel_t [2:0] pixel3_t;
    typedef pixel_t [8:0] pixel9_t;

    // Control that travels beside the data through every stage.
    typedef struct packed {
        logic   valid;
        logic   filter;
        pixel_t centre;
    } ctrl_t;

    localparam pixel_t PIX_MIN = 8'h00;
    localparam pixel_t PIX_MAX = 8'hFF;

    localparam int unsigned TAP_PAIRS = 4;
    localparam int unsigned TAP_COUNT = 2 * TAP_PAIRS + 1;

    localparam logic [3:0] TAP_MODE_RESET    = 4'd1;
    localparam logic       PROCESS_ALL_RESET = 1'b0;

    // Configuration register indexes.
    localparam logic CFG_TAP_MODE    = 1'b0;
    localparam logic CFG_PROCESS_ALL = 1'b1;

    function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
    endfunction

    // Returns the three values in ascending order, index 0 the smallest.
    function automatic pixel3_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel3_t s;
        s[0] = pix_min(pix_min(a, b), c);
        s[1] = med3(a, b, c);
        s[2] = pix_max(pix_max(a, b), c);
        return s;
    endfunction

endpackage

// File: rtl/snm_tap_gather.sv
module snm_tap_gather
    import snm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  pixel9_t        in_pixels,
    input  logic           suspect,
    input  logic [3:0]     tap_mode,
    input  logic           process_all,
    output pixel9_t        taps,
    output ctrl_t          ctrl
);

    pixel9_t taps_reg;
    pixel9_t taps_next;
    ctrl_t   ctrl_next;
    logic    valid_reg;
    logic    filter_reg;
    pixel_t  centre_reg;

    // A pair that is not selected becomes the darkest and brightest values,
    // which leaves the median of the remaining taps unchanged.
    always_comb
    begin
        taps_next[0] = in_pixels[0];
        for (int p = 0; p < TAP_PAIRS; p++)
        begin
            if (tap_mode[p])
            begin
                taps_next[2 * p + 1] = in_pixels[2 * p + 1];
                taps_next[2 * p + 2] = in_pixels[2 * p + 2];
            end
            else
            begin
                taps_next[2 * p + 1] = PIX_MIN;
                taps_next[2 * p + 2] = PIX_MAX;
            end
        end
        ctrl_next.valid  = in_valid;
        ctrl_next.filter = process_all | suspect;
        ctrl_next.centre = in_pixels[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            taps_reg   <= taps_next;
            filter_reg <= ctrl_next.filter;
            centre_reg <= ctrl_next.centre;
        end
    end

    assign taps = taps_reg;
    assign ctrl = {valid_reg, filter_reg, centre_reg};

endmodule

// File: rtl/snm_median9.sv
module snm_median9
    import snm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  pixel9_t taps,
    input  ctrl_t   ctrl_in,
    output pixel_t  result,
    output logic    result_valid
);

    // Stage A: each row of three sorted.
    pixel3_t row0_reg, row1_reg, row2_reg;
    pixel3_t row0_next, row1_next, row2_next;
    logic    valid_a_reg;
    logic    filter_a_reg;
    pixel_t  centre_a_reg;

    // Stage B: max of minima, median of medians, min of maxima.
    pixel_t  lo_reg, mid_reg, hi_reg;
    pixel_t  lo_next, mid_next, hi_next;
    logic    valid_b_reg;
    logic    filter_b_reg;
    pixel_t  centre_b_reg;

    // Stage C: final median or the untouched centre.
    pixel_t  result_reg;
    pixel_t  result_next;
    logic    valid_c_reg;

    always_comb
    begin
        row0_next = sort3(taps[0], taps[1], taps[2]);
        row1_next = sort3(taps[3], taps[4], taps[5]);
        row2_next = sort3(taps[6], taps[7], taps[8]);

        lo_next  = pix_max(pix_max(row0_reg[0], row1_reg[0]), row2_reg[0]);
        mid_next = med3(row0_reg[1], row1_reg[1], row2_reg[1]);
        hi_next  = pix_min(pix_min(row0_reg[2], row1_reg[2]), row2_reg[2]);

        result_next = filter_b_reg ? med3(lo_reg, mid_reg, hi_reg)
                                   : centre_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= ctrl_in.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row0_reg     <= row0_next;
            row1_reg     <= row1_next;
            row2_reg     <= row2_next;
            filter_a_reg <= ctrl_in.filter;
            centre_a_reg <= ctrl_in.centre;

            lo_reg       <= lo_next;
            mid_reg      <= mid_next;
            hi_reg       <= hi_next;
            filter_b_reg <= filter_a_reg;
            centre_b_reg <= centre_a_reg;

            result_reg   <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_c_reg;

endmodule

// File: rtl/selectable_neighbour_median_top.sv
// A request accepted into the tap gather register passes through the row sort and column
// merge registers into the output register, from which the result can be taken.
// Throughput: one request per clock; the four-stage pipeline (tap gather, row sort,
// column merge, final median) holds as long as the output is taken every cycle.
// Backpressure stalls all four stages together, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets tap_mode to 1, process_all to 0.
module selectable_neighbour_median_top
    import snm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0 up: centre_pixel, prev_frame_pixel, next_frame_pixel, left_pixel,
    // right_pixel, above_pixel, below_pixel, above_two_pixel, below_two_pixel.
    input  logic [71:0] s_axis_tdata,
    // Bit 0: suspect.
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits 7:0: cleaned_pixel.
    output logic [7:0]  m_axis_tdata,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    logic [3:0] tap_mode_reg;
    logic       process_all_reg;

    pixel9_t    in_pixels;
    pixel9_t    taps;
    ctrl_t      gather_ctrl;
    pixel_t     result;
    logic       result_valid;
    logic       en;

    // The whole pipeline moves whenever the output register is empty or
    // being drained this cycle. A request enters in the same condition.
    assign en            = !result_valid || m_axis_tready;
    assign s_axis_tready = en;

    // The stream word packs the centre and its eight neighbours, centre lowest.
    assign in_pixels = pixel9_t'(s_axis_tdata);

    // Configuration must only be written while the pipeline is empty, so the registers
    // feed the gather stage directly; the user is bound to this, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_mode_reg    <= TAP_MODE_RESET;
            process_all_reg <= PROCESS_ALL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAP_MODE:    tap_mode_reg    <= cfg_data;
                CFG_PROCESS_ALL: process_all_reg <= cfg_data[0];
            endcase
        end
    end

    // First stage: unselected neighbour pairs are replaced by a darkest and
    // brightest pair so the sorting network always sees nine values.
    snm_tap_gather u_gather (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .in_pixels   (in_pixels),
        .suspect     (s_axis_tuser),
        .tap_mode    (tap_mode_reg),
        .process_all (process_all_reg),
        .taps        (taps),
        .ctrl        (gather_ctrl)
    );

    // Stages two to four: median of nine by sorting rows, merging columns,
    // and taking the median of the three survivors. The last stage is the
    // output register, which also selects the centre for unfiltered pixels.
    snm_median9 u_median (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .taps         (taps),
        .ctrl_in      (gather_ctrl),
        .result       (result),
        .result_valid (result_valid)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tdata  = result;

endmodule

// File: rtl/snm_checker.sv
module snm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled result keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // A stalled output stalls the input side too.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while output is stalled");

    // An empty output never holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // With the output drained every cycle, an accepted request shows up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready
         ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready) |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // Reset empties the pipeline by the next edge.
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind selectable_neighbour_median_top snm_checker u_snm_checker (.*);

// File: tb/tb_top.sv
module tb_top
    import snm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One neighbourhood as the filter sees it. The neighbours are kept in tdata order:
    // previous frame, next frame, left, right, above, below, two above, two below.
    // Entries 2p and 2p+1 therefore form the pair that tap_mode bit p selects.
    typedef struct {
        pixel_t centre;
        pixel_t nbr [8];
        logic   suspect;
    } window_t;

    // The watchdog limit is far above the slowest legal run. That run has about 1150
    // requests, idle sender gaps between bursts, a receiver that takes one result in
    // four, one long hold-off and a drain between every pair of phases.
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned LONG_HOLD     = 120;
    localparam int unsigned HOLD_AFTER    = 450;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 95;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b1;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we         = 1'b0;
    logic        cfg_index      = 1'b0;
    logic [3:0]  cfg_data       = '0;

    // These registers mirror the filter configuration. They change only while the
    // block is idle.
    logic [3:0] active_taps   = TAP_MODE_RESET;
    logic       process_every = PROCESS_ALL_RESET;

    window_t     pending_windows [$];
    pixel_t      expected_pixels [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Sender state. A burst runs until burst_left reaches zero. The sender then idles
    // while gap_left counts down. A gap_left of zero joins two bursts, which gives
    // stretches with no idling at all.
    window_t     window_on_bus;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // Receiver state. The stall style is chosen again for each stretch of cycles.
    int unsigned stall_style    = 0;
    int unsigned stretch_left   = 0;
    int unsigned hold_left      = 0;
    int unsigned results_taken  = 0;
    logic        long_hold_done = 1'b0;

    selectable_neighbour_median_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicts the cleaned pixel. The centre and the selected pairs are gathered. The
    // median is the value whose rank window covers the middle position. This copes
    // with repeated values without sorting the list.
    function automatic pixel_t median_or_centre(input window_t w, input logic [3:0] taps,
                                                input logic every);
        pixel_t      gathered [TAP_COUNT];
        int unsigned count;
        int unsigned lower;
        int unsigned not_above;
        pixel_t      cleaned;
        cleaned = w.centre;
        if (every || w.suspect)
        begin
            gathered[0] = w.centre;
            count = 1;
            for (int p = 0; p < TAP_PAIRS; p++)
            begin
                if (taps[p])
                begin
                    gathered[count]     = w.nbr[2 * p];
                    gathered[count + 1] = w.nbr[2 * p + 1];
                    count += 2;
                end
            end
            for (int i = 0; i < count; i++)
            begin
                lower     = 0;
                not_above = 0;
                for (int j = 0; j < count; j++)
                begin
                    if (gathered[j] < gathered[i])
                        lower++;
                    if (gathered[j] <= gathered[i])
                        not_above++;
                end
                if (lower <= count / 2 && not_above > count / 2)
                    cleaned = gathered[i];
            end
        end
        return cleaned;
    endfunction

    // Builds a flat window: every neighbour carries the same value.
    function automatic window_t flat_window(input pixel_t centre, input pixel_t others,
                                            input logic suspect);
        window_t w;
        w.centre  = centre;
        w.suspect = suspect;
        for (int i = 0; i < 8; i++)
            w.nbr[i] = others;
        return w;
    endfunction

    // Builds a window with spread-out neighbours.
    function automatic window_t spread_window(input pixel_t centre, input logic suspect);
        window_t w;
        w.centre  = centre;
        w.suspect = suspect;
        w.nbr     = '{8'd200, 8'd10, 8'd90, 8'd30, 8'd250, 8'd5, 8'd120, 8'd60};
        return w;
    endfunction

    // Builds a random window in one of three styles. Uniform values exercise every bit.
    // Values at the two rails stress the comparators. Tight clusters produce many equal
    // values.
    function automatic window_t random_window(input int unsigned suspect_odds);
        window_t     w;
        int unsigned style;
        int unsigned base;
        style     = $urandom_range(0, 2);
        base      = $urandom_range(0, 255);
        w.suspect = ($urandom_range(0, 99) < suspect_odds);
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            pixel_t v;
            case (style)
                0:       v = pixel_t'($urandom_range(0, 255));
                1:       v = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
                default: v = pixel_t'(base + $urandom_range(0, 6));
            endcase
            if (i == 0)
                w.centre = v;
            else
                w.nbr[i - 1] = v;
        end
        return w;
    endfunction

    // Waits at falling edges until every request has been accepted and answered.
    // It then lets the pipeline settle.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_windows.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers while the block is idle. The process_all write takes the
    // full 4-bit data word, and only bit 0 counts.
    task automatic set_filter(input logic [3:0] taps, input logic [3:0] every_data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAP_MODE;
        cfg_data  <= taps;
        @(posedge clk);
        cfg_index <= CFG_PROCESS_ALL;
        cfg_data  <= every_data;
        @(posedge clk);
        cfg_we        <= 1'b0;
        active_taps   = taps;
        process_every = every_data[0];
        @(negedge clk);
    endtask

    // Sender. At each edge it first records an accepted request and predicts its
    // result. It then decides what the bus carries next. Each output is assigned once
    // per edge.
    always @(posedge clk)
    begin
        logic        offering;
        logic [71:0] packed_window;
        if (rst_n)
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_pixels.push_back(
                    median_or_centre(window_on_bus, active_taps, process_every));
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_windows.size() > 0)
                begin
                    window_on_bus = pending_windows.pop_front();
                    offering      = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            packed_window[7:0] = window_on_bus.centre;
            for (int i = 0; i < 8; i++)
                packed_window[8 * (i + 1) +: 8] = window_on_bus.nbr[i];
            s_axis_tvalid <= offering;
            s_axis_tdata  <= packed_window;
            s_axis_tuser  <= window_on_bus.suspect;
        end
    end

    // Receiver. It stalls in stretches that always take a result, take half of them at
    // random, or take about one in four. Once, after enough results, it holds off for
    // a long stretch. The pipeline then backs up and the sender sees tready drop.
    always @(posedge clk)
    begin
        logic ready_next;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!long_hold_done && results_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                ready_next     = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_style  = $urandom_range(0, 2);
                    stretch_left = $urandom_range(8, 60);
                end
                stretch_left--;
                case (stall_style)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Checker. Every accepted result must match the oldest prediction still waiting.
    always @(posedge clk)
    begin
        pixel_t predicted;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected cleaned pixel %0d, none expected", $time,
                         m_axis_tdata);
                error_count++;
            end
            else
            begin
                predicted = expected_pixels.pop_front();
                if (m_axis_tdata !== predicted)
                begin
                    $display("%0t: cleaned pixel expected %0d, got %0d", $time,
                             predicted, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset configuration uses the temporal pair only and filters suspect
        // pixels only.
        pending_windows.push_back(spread_window(8'd17, 1'b0));
        pending_windows.push_back(spread_window(8'd17, 1'b1));
        wait_until_idle();

        // All pairs are selected with every pixel filtered. The windows cover both
        // rails, a lone outlier at each rail and a full spread of nine values.
        set_filter(4'hF, 4'h1);
        pending_windows.push_back(flat_window(PIX_MIN, PIX_MIN, 1'b0));
        pending_windows.push_back(flat_window(PIX_MAX, PIX_MAX, 1'b0));
        pending_windows.push_back(flat_window(PIX_MIN, PIX_MAX, 1'b0));
        pending_windows.push_back(flat_window(PIX_MAX, PIX_MIN, 1'b1));
        pending_windows.push_back(spread_window(8'd100, 1'b0));
        pending_windows.push_back(spread_window(8'd255, 1'b1));
        wait_until_idle();

        // No pair is selected, so even a filtered pixel comes back as its centre.
        set_filter(4'h0, 4'hF);
        pending_windows.push_back(flat_window(PIX_MAX, PIX_MIN, 1'b1));
        pending_windows.push_back(flat_window(PIX_MIN, PIX_MAX, 1'b0));
        wait_until_idle();

        // Bit 0 of the process_all data is clear, so only the suspect flag decides.
        set_filter(4'hF, 4'hE);
        pending_windows.push_back(flat_window(8'd9, 8'd200, 1'b0));
        pending_windows.push_back(flat_window(8'd9, 8'd200, 1'b1));
        wait_until_idle();

        // Each single pair on its own. The result is the median of three values.
        for (int p = 0; p < TAP_PAIRS; p++)
        begin
            set_filter(4'(1 << p), 4'h0);
            pending_windows.push_back(spread_window(8'd70, 1'b1));
            wait_until_idle();
        end

        // Random phases. Each one has its own configuration and suspect rate.
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            int unsigned suspect_odds;
            logic [3:0]  taps;
            taps = (k == 0) ? 4'hF : (k == 1) ? 4'h0 : 4'($urandom_range(0, 15));
            suspect_odds = $urandom_range(0, 100);
            set_filter(taps, 4'($urandom_range(0, 15)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_windows.push_back(random_window(suspect_odds));
            wait_until_idle();
        end

        // Any late or extra result would show up in these last cycles.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
